@@ src/bfs_augmenting_max_flow_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the max-flow unit
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BFS_AUGMENTING_MAX_FLOW_UNIT_ASSERT_SVH
`define BFS_AUGMENTING_MAX_FLOW_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define BFSMF_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("check failed");

// antecedent implies consequent in the next cycle
`define BFSMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

@@ src/bfsmf_pkg.sv @@
// ----------------------------------------------------------------------------
// bfsmf_pkg
// Shared types and codes of the max-flow unit.
// ----------------------------------------------------------------------------
package bfsmf_pkg;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_SOLVE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic CFG_SOURCE = 1'b0;
  localparam logic CFG_SINK   = 1'b1;

  localparam logic KIND_FLOW  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef struct packed {
    logic [5:0]        tail;
    logic [5:0]        head;
    logic [7:0]        cap;
    logic signed [8:0] flow;
  } edge_entry_t;

endpackage

@@ src/bfsmf_edge_mem.sv @@
// ----------------------------------------------------------------------------
// bfsmf_edge_mem
// Edge table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfsmf_edge_mem
  import bfsmf_pkg::*;
#(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  edge_entry_t   wdata,
  input  logic [AW-1:0] raddr,
  output edge_entry_t   rdata
);

  edge_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/bfsmf_vtx_mem.sv @@
// ----------------------------------------------------------------------------
// bfsmf_vtx_mem
// Per-vertex visit mark and parent entry, plus the search queue.
// ----------------------------------------------------------------------------
module bfsmf_vtx_mem
  import bfsmf_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int VW    = 6,
  parameter int EW    = 9
) (
  input  logic          clk,
  input  logic          v_we,
  input  logic [VW-1:0] v_waddr,
  input  logic          v_wvis,
  input  logic [EW-1:0] v_wpar,
  input  logic [VW-1:0] v_raddr,
  output logic          v_rvis,
  output logic [EW-1:0] v_rpar,
  input  logic          q_we,
  input  logic [VW-1:0] q_waddr,
  input  logic [5:0]    q_wdata,
  input  logic [VW-1:0] q_raddr,
  output logic [5:0]    q_rdata
);

  logic [EW:0] vmem [DEPTH];
  logic [5:0]  qmem [DEPTH];

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_waddr] <= {v_wvis, v_wpar};
    end
    {v_rvis, v_rpar} <= vmem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
    q_rdata <= qmem[q_raddr];
  end

endmodule

@@ src/bfs_augmenting_max_flow_unit.sv @@
// ----------------------------------------------------------------------------
// bfs_augmenting_max_flow_unit
// Edmonds-Karp max flow over an edge table held in synchronous memory.
// ----------------------------------------------------------------------------
// An add that fits writes the forward entry, then its reverse twin; busy is high
// for one cycle. A clear does not raise busy. A solve is sequenced over the edge
// memory: each search first sweeps the vertex table, then every dequeued vertex
// scans all stored entries, and each path found is walked twice, once for the
// bottleneck and once for the update. Unless source equals sink or either is out
// of range, busy stays high until the result. Results appear on out_valid for one
// cycle and must be taken then: there is no stall from the receiver.
module bfs_augmenting_max_flow_unit
  import bfsmf_pkg::*;
#(
  parameter int MAX_VERTICES     = 64,
  parameter int MAX_EDGE_ENTRIES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [5:0]  in_src_vertex,
  input  logic [5:0]  in_dst_vertex,
  input  logic [7:0]  in_edge_capacity,
  output logic        out_valid,
  output logic [15:0] out_max_flow,
  output logic        out_table_full_error,
  output logic        out_result_kind,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_wdata
);

  `include "bfs_augmenting_max_flow_unit_assert.svh"

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EW = (MAX_EDGE_ENTRIES > 1) ? $clog2(MAX_EDGE_ENTRIES) : 1;
  localparam logic [EW:0] ECAP   = (EW+1)'(MAX_EDGE_ENTRIES);
  localparam logic [VW:0] QCAP   = (VW+1)'(MAX_VERTICES);
  localparam logic [VW-1:0] VLAST = VW'(MAX_VERTICES - 1);
  localparam logic [31:0] VLIM   = 32'(MAX_VERTICES);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001, S_ADD2 = 17'h00002, S_CLR  = 17'h00004,
    S_SEED = 17'h00008, S_POP  = 17'h00010, S_POPW = 17'h00020,
    S_ERD  = 17'h00040, S_EDAT = 17'h00080, S_VDAT = 17'h00100,
    S_CHK  = 17'h00200, S_BV   = 17'h00400, S_BVW  = 17'h00800,
    S_BE   = 17'h01000, S_PV   = 17'h02000, S_PVW  = 17'h04000,
    S_PE   = 17'h08000, S_PT   = 17'h10000
  } state_t;

  state_t state_r, state_nxt;
  logic [EW:0]   ecnt_r, ecnt_nxt;
  logic [5:0]    src_r, snk_r;
  logic [VW-1:0] sw_r, sw_nxt;
  logic [VW:0]   qhead_r, qhead_nxt, qtail_r, qtail_nxt;
  logic [5:0]    cur_r, cur_nxt, hd_r, hd_nxt, v_r, v_nxt;
  logic [5:0]    a_r, a_nxt, b_r, b_nxt;
  logic [EW:0]   e_r, e_nxt;
  logic [EW-1:0] pe_r, pe_nxt;
  logic [9:0]    bn_r, bn_nxt;
  logic [15:0]   total_r, total_nxt;
  logic          ov_r, ov_nxt, ok_r, ok_nxt;
  logic [15:0]   of_r, of_nxt;

  logic          e_we;
  logic [EW-1:0] e_waddr, e_raddr;
  edge_entry_t   e_wdata, e_rdata;
  logic          v_we, v_wvis, v_rvis;
  logic [VW-1:0] v_waddr, v_raddr;
  logic [EW-1:0] v_wpar, v_rpar;
  logic          q_we;
  logic [VW-1:0] q_waddr, q_raddr;
  logic [5:0]    q_wdata, q_rdata;

  logic          trivial;
  logic [9:0]    room;
  logic [16:0]   tsum;
  logic [9:0]    fsum;

  bfsmf_edge_mem #(.DEPTH(MAX_EDGE_ENTRIES), .AW(EW)) u_edge (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );

  bfsmf_vtx_mem #(.DEPTH(MAX_VERTICES), .VW(VW), .EW(EW)) u_vtx (
    .clk, .v_we, .v_waddr, .v_wvis, .v_wpar, .v_raddr, .v_rvis, .v_rpar,
    .q_we, .q_waddr, .q_wdata, .q_raddr, .q_rdata
  );

  assign trivial = (src_r == snk_r) || ({26'd0, src_r} >= VLIM) || ({26'd0, snk_r} >= VLIM);
  assign room    = {2'b00, e_rdata.cap} - {e_rdata.flow[8], e_rdata.flow};
  assign tsum    = {1'b0, total_r} + {7'd0, bn_r};

  always_comb begin
    state_nxt = state_r;
    ecnt_nxt  = ecnt_r;
    sw_nxt    = sw_r;
    qhead_nxt = qhead_r;
    qtail_nxt = qtail_r;
    cur_nxt   = cur_r;
    hd_nxt    = hd_r;
    v_nxt     = v_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    e_nxt     = e_r;
    pe_nxt    = pe_r;
    bn_nxt    = bn_r;
    total_nxt = total_r;
    ov_nxt    = 1'b0;
    ok_nxt    = ok_r;
    of_nxt    = of_r;
    e_we      = 1'b0;
    e_waddr   = ecnt_r[EW-1:0];
    e_wdata   = '{tail: in_src_vertex, head: in_dst_vertex, cap: in_edge_capacity, flow: '0};
    e_raddr   = e_r[EW-1:0];
    v_we      = 1'b0;
    v_waddr   = sw_r;
    v_wvis    = 1'b0;
    v_wpar    = e_r[EW-1:0];
    v_raddr   = VW'(snk_r);
    q_we      = 1'b0;
    q_waddr   = qtail_r[VW-1:0];
    q_wdata   = hd_r;
    q_raddr   = qhead_r[VW-1:0];
    fsum      = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_func)
            FUNC_ADD: begin
              if (ecnt_r + (EW+1)'(2) > ECAP) begin
                ov_nxt = 1'b1;
                ok_nxt = KIND_ERROR;
                of_nxt = '0;
              end else begin
                e_we      = 1'b1;
                a_nxt     = in_src_vertex;
                b_nxt     = in_dst_vertex;
                state_nxt = S_ADD2;
              end
            end
            FUNC_SOLVE: begin
              total_nxt = '0;
              if (trivial) begin
                ov_nxt = 1'b1;
                ok_nxt = KIND_FLOW;
                of_nxt = '0;
              end else begin
                sw_nxt    = '0;
                state_nxt = S_CLR;
              end
            end
            FUNC_CLEAR: ecnt_nxt = '0;
            default: ;
          endcase
        end
      end
      S_ADD2: begin
        e_we      = 1'b1;
        e_waddr   = EW'(ecnt_r + (EW+1)'(1));
        e_wdata   = '{tail: b_r, head: a_r, cap: 8'd0, flow: '0};
        ecnt_nxt  = ecnt_r + (EW+1)'(2);
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        v_we   = 1'b1;
        sw_nxt = sw_r + VW'(1);
        if (sw_r == VLAST) begin
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        v_we      = 1'b1;
        v_waddr   = VW'(src_r);
        v_wvis    = 1'b1;
        q_we      = 1'b1;
        q_waddr   = '0;
        q_wdata   = src_r;
        qhead_nxt = '0;
        qtail_nxt = (VW+1)'(1);
        state_nxt = S_POP;
      end
      S_POP: begin
        if (qhead_r == qtail_r) begin
          state_nxt = S_CHK;
        end else begin
          qhead_nxt = qhead_r + (VW+1)'(1);
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        cur_nxt   = q_rdata;
        e_nxt     = '0;
        state_nxt = S_ERD;
      end
      S_ERD: begin
        state_nxt = (e_r == ecnt_r) ? S_POP : S_EDAT;
      end
      S_EDAT: begin
        hd_nxt  = e_rdata.head;
        v_raddr = VW'(e_rdata.head);
        if (e_rdata.tail == cur_r && {26'd0, e_rdata.head} < VLIM &&
            $signed({1'b0, e_rdata.cap}) > e_rdata.flow) begin
          state_nxt = S_VDAT;
        end else begin
          e_nxt     = e_r + (EW+1)'(1);
          state_nxt = S_ERD;
        end
      end
      S_VDAT: begin
        if (!v_rvis) begin
          v_we    = 1'b1;
          v_waddr = VW'(hd_r);
          v_wvis  = 1'b1;
          if (qtail_r < QCAP) begin
            q_we      = 1'b1;
            qtail_nxt = qtail_r + (VW+1)'(1);
          end
        end
        e_nxt     = e_r + (EW+1)'(1);
        state_nxt = S_ERD;
      end
      S_CHK: begin
        if (!v_rvis) begin
          ov_nxt    = 1'b1;
          ok_nxt    = KIND_FLOW;
          of_nxt    = total_r;
          state_nxt = S_IDLE;
        end else begin
          v_nxt     = snk_r;
          bn_nxt    = '1;
          state_nxt = S_BV;
        end
      end
      S_BV: begin
        v_raddr = VW'(v_r);
        if (v_r == src_r) begin
          v_nxt     = snk_r;
          state_nxt = S_PV;
        end else begin
          state_nxt = S_BVW;
        end
      end
      S_BVW: begin
        e_raddr   = v_rpar;
        state_nxt = S_BE;
      end
      S_BE: begin
        if (room < bn_r) begin
          bn_nxt = room;
        end
        v_nxt     = e_rdata.tail;
        state_nxt = S_BV;
      end
      S_PV: begin
        v_raddr = VW'(v_r);
        if (v_r == src_r) begin
          total_nxt = tsum[16] ? 16'hFFFF : tsum[15:0];
          sw_nxt    = '0;
          state_nxt = S_CLR;
        end else begin
          state_nxt = S_PVW;
        end
      end
      S_PVW: begin
        e_raddr   = v_rpar;
        pe_nxt    = v_rpar;
        state_nxt = S_PE;
      end
      S_PE: begin
        fsum      = {e_rdata.flow[8], e_rdata.flow} + bn_r;
        e_we      = 1'b1;
        e_waddr   = pe_r;
        e_wdata   = '{tail: e_rdata.tail, head: e_rdata.head, cap: e_rdata.cap,
                      flow: fsum[8:0]};
        e_raddr   = pe_r ^ EW'(1);
        v_nxt     = e_rdata.tail;
        state_nxt = S_PT;
      end
      S_PT: begin
        fsum      = {e_rdata.flow[8], e_rdata.flow} - bn_r;
        e_we      = 1'b1;
        e_waddr   = pe_r ^ EW'(1);
        e_wdata   = '{tail: e_rdata.tail, head: e_rdata.head, cap: e_rdata.cap,
                      flow: fsum[8:0]};
        state_nxt = S_PV;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ecnt_r  <= '0;
      src_r   <= 6'd0;
      snk_r   <= 6'd1;
      ov_r    <= 1'b0;
      qhead_r <= '0;
      qtail_r <= '0;
    end else begin
      state_r <= state_nxt;
      ecnt_r  <= ecnt_nxt;
      ov_r    <= ov_nxt;
      qhead_r <= qhead_nxt;
      qtail_r <= qtail_nxt;
      if (cfg_we && cfg_index == CFG_SOURCE) begin
        src_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_SINK) begin
        snk_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    sw_r    <= sw_nxt;
    cur_r   <= cur_nxt;
    hd_r    <= hd_nxt;
    v_r     <= v_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    e_r     <= e_nxt;
    pe_r    <= pe_nxt;
    bn_r    <= bn_nxt;
    total_r <= total_nxt;
    ok_r    <= ok_nxt;
    of_r    <= of_nxt;
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = ov_r;
  assign out_max_flow         = of_r;
  assign out_result_kind      = ok_r;
  assign out_table_full_error = ok_r;

  `BFSMF_ASSERT(a_count_bound, ecnt_r <= ECAP)
  `BFSMF_ASSERT(a_queue_order, qhead_r <= qtail_r)
  `BFSMF_ASSERT_NEXT(a_add_twin, state_r == S_ADD2, ecnt_r == $past(ecnt_r) + (EW+1)'(2))
  `BFSMF_ASSERT(a_err_zero, !(out_valid && out_result_kind == KIND_ERROR) || out_max_flow == 16'd0)

endmodule

@@ bench/tb_bfs_augmenting_max_flow_unit.sv @@
// ----------------------------------------------------------------------------
// tb_bfs_augmenting_max_flow_unit
// Self-checking bench for the max-flow unit: drives edge adds, solves, clears
// and no-ops with random gaps, predicts each result from a local copy of the
// edge table and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module tb_bfs_augmenting_max_flow_unit;
  import bfsmf_pkg::*;

  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int NV = 64;
  localparam int NE = 512;
  localparam int CYCLE_LIMIT = 40000000;

  typedef struct {
    logic [15:0] flow;
    logic        full_err;
    logic        kind;
  } flow_result_t;

  logic        clk, rst_n, start, busy;
  logic [1:0]  in_func;
  logic [5:0]  in_src_vertex, in_dst_vertex;
  logic [7:0]  in_edge_capacity;
  logic        out_valid;
  logic [15:0] out_max_flow;
  logic        out_table_full_error, out_result_kind;
  logic        cfg_we, cfg_index;
  logic [5:0]  cfg_wdata;

  bfs_augmenting_max_flow_unit u_top (.*);

  // local copy of the edge table
  logic [5:0]  pred_src, pred_sink;
  logic [5:0]  tbl_tail [NE];
  logic [5:0]  tbl_head [NE];
  int          tbl_cap  [NE];
  int          tbl_flow [NE];
  int          tbl_count;
  int          reach_via [NV];

  flow_result_t pending_results[$];
  int  mismatches, items_sent, results_seen, solves_sent, errors_seen;
  int  cycles;
  bit  burst_mode;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void queue_expected(flow_result_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic bit find_path(logic [5:0] s, logic [5:0] t);
    bit seen [NV];
    int order [NV];
    int qh, qt, cur, nb;
    for (int v = 0; v < NV; v++) seen[v] = 0;
    qh = 0;
    qt = 0;
    seen[s] = 1;
    order[qt++] = s;
    while (qh < qt) begin
      cur = order[qh++];
      for (int e = 0; e < tbl_count; e++) begin
        nb = tbl_head[e];
        if (tbl_tail[e] == cur && !seen[nb] && tbl_cap[e] > tbl_flow[e]) begin
          seen[nb] = 1;
          reach_via[nb] = e;
          if (qt < NV) order[qt++] = nb;
        end
      end
    end
    return seen[t];
  endfunction

  function automatic logic [15:0] augment_all();
    int total, room, bneck, v, e;
    total = 0;
    if (pred_src == pred_sink) return 16'd0;
    while (find_path(pred_src, pred_sink)) begin
      bneck = 32'h7fffffff;
      v = pred_sink;
      while (v != pred_src) begin
        e = reach_via[v];
        room = tbl_cap[e] - tbl_flow[e];
        if (room < bneck) bneck = room;
        v = tbl_tail[e];
      end
      v = pred_sink;
      while (v != pred_src) begin
        e = reach_via[v];
        tbl_flow[e] += bneck;
        tbl_flow[e ^ 1] -= bneck;
        v = tbl_tail[e];
      end
      total += bneck;
      if (total > 65535) total = 65535;
    end
    return total[15:0];
  endfunction

  function automatic void predict_item(logic [1:0] f, logic [5:0] a, logic [5:0] b,
                                       logic [7:0] c);
    flow_result_t r;
    case (f)
      FUNC_ADD: begin
        if (tbl_count + 2 > NE) begin
          r.flow = 16'd0;
          r.full_err = 1'b1;
          r.kind = KIND_ERROR;
          queue_expected(r);
        end else begin
          tbl_tail[tbl_count] = a;
          tbl_head[tbl_count] = b;
          tbl_cap[tbl_count] = c;
          tbl_flow[tbl_count] = 0;
          tbl_tail[tbl_count + 1] = b;
          tbl_head[tbl_count + 1] = a;
          tbl_cap[tbl_count + 1] = 0;
          tbl_flow[tbl_count + 1] = 0;
          tbl_count += 2;
        end
      end
      FUNC_SOLVE: begin
        r.flow = augment_all();
        r.full_err = 1'b0;
        r.kind = KIND_FLOW;
        queue_expected(r);
        solves_sent++;
      end
      FUNC_CLEAR: tbl_count = 0;
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [1:0] f, logic [5:0] a, logic [5:0] b, logic [7:0] c);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_src_vertex <= a;
    in_dst_vertex <= b;
    in_edge_capacity <= c;
    do @(posedge clk); while (busy);
    predict_item(f, a, b, c);
    items_sent++;
  endtask

  // hold until every result is in and the unit has gone quiet
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (busy || pending_results.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [5:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SOURCE) pred_src = val;
    else pred_sink = val;
  endtask

  always @(posedge clk) begin
    flow_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_result_kind == KIND_ERROR) errors_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result transfer: flow %0d err %0b kind %0b", $realtime,
                 out_max_flow, out_table_full_error, out_result_kind);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_max_flow !== want.flow) begin
          $display("%0t max_flow expected %0d actual %0d", $realtime, want.flow,
                   out_max_flow);
          mismatches++;
        end
        if (out_table_full_error !== want.full_err) begin
          $display("%0t table_full_error expected %0b actual %0b", $realtime,
                   want.full_err, out_table_full_error);
          mismatches++;
        end
        if (out_result_kind !== want.kind) begin
          $display("%0t result_kind expected %0b actual %0b", $realtime, want.kind,
                   out_result_kind);
          mismatches++;
        end
      end
    end
  end

  task automatic test_directed();
    burst_mode = 0;
    send_item(FUNC_SOLVE, 6'd0, 6'd0, 8'd0);
    send_item(FUNC_ADD, 6'd0, 6'd1, 8'd255);
    send_item(FUNC_ADD, 6'd0, 6'd2, 8'd0);
    send_item(FUNC_ADD, 6'd2, 6'd1, 8'd7);
    send_item(FUNC_ADD, 6'd0, 6'd3, 8'd9);
    send_item(FUNC_ADD, 6'd3, 6'd3, 8'd200);
    send_item(FUNC_ADD, 6'd3, 6'd2, 8'd5);
    send_item(FUNC_ADD, 6'd3, 6'd1, 8'd3);
    send_item(FUNC_ADD, 6'd63, 6'd63, 8'd1);
    send_item(FUNC_SOLVE, 6'd63, 6'd63, 8'd255);
    send_item(FUNC_SOLVE, 6'd0, 6'd0, 8'd0);
    send_item(FUNC_ADD, 6'd2, 6'd1, 8'd2);
    send_item(FUNC_NOP, 6'd21, 6'd42, 8'd170);
    send_item(FUNC_SOLVE, 6'd0, 6'd0, 8'd0);
    write_reg(CFG_SINK, 6'd0);
    send_item(FUNC_SOLVE, 6'd0, 6'd0, 8'd0);
    write_reg(CFG_SOURCE, 6'd63);
    write_reg(CFG_SINK, 6'd62);
    send_item(FUNC_CLEAR, 6'd0, 6'd0, 8'd0);
    send_item(FUNC_ADD, 6'd63, 6'd62, 8'd128);
    send_item(FUNC_ADD, 6'd62, 6'd63, 8'd64);
    send_item(FUNC_SOLVE, 6'd0, 6'd0, 8'd0);
    send_item(FUNC_CLEAR, 6'd63, 6'd63, 8'd255);
    send_item(FUNC_SOLVE, 6'd0, 6'd0, 8'd0);
  endtask

  task automatic test_table_full();
    write_reg(CFG_SOURCE, 6'd0);
    write_reg(CFG_SINK, 6'd1);
    burst_mode = 1;
    send_item(FUNC_CLEAR, 6'd0, 6'd0, 8'd0);
    for (int i = 0; i < NE / 2; i++)
      send_item(FUNC_ADD, 6'(2 + i / 8), 6'(34 + i % 8), 8'($urandom_range(0, 255)));
    burst_mode = 0;
    send_item(FUNC_ADD, 6'd0, 6'd1, 8'd10);
    send_item(FUNC_ADD, 6'd63, 6'd0, 8'd255);
    send_item(FUNC_SOLVE, 6'd0, 6'd0, 8'd0);
    send_item(FUNC_CLEAR, 6'd0, 6'd0, 8'd0);
    send_item(FUNC_ADD, 6'd0, 6'd1, 8'd10);
    send_item(FUNC_SOLVE, 6'd0, 6'd0, 8'd0);
  endtask

  task automatic test_random_graphs();
    logic [5:0] pool [8];
    logic [5:0] s, t;
    int k, r;
    while (items_sent < 1250) begin
      case ($urandom_range(0, 5))
        0: s = 6'd0;
        1: s = 6'd63;
        default: s = 6'($urandom_range(0, 63));
      endcase
      t = ($urandom_range(0, 9) == 0) ? s : 6'($urandom_range(0, 63));
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_SOURCE, s);
        write_reg(CFG_SINK, t);
      end else begin
        write_reg(CFG_SINK, t);
        write_reg(CFG_SOURCE, s);
      end
      pool[0] = s;
      pool[1] = t;
      for (int i = 2; i < 8; i++) pool[i] = 6'($urandom_range(0, 63));
      burst_mode = $urandom_range(0, 3) == 0;
      send_item(FUNC_CLEAR, 6'($urandom), 6'($urandom), 8'($urandom));
      k = 0;
      for (int n = 0; n < 30; n++) begin
        r = $urandom_range(0, 99);
        if (r < 65 && k < 18) begin
          send_item(FUNC_ADD, pool[$urandom_range(0, 7)], pool[$urandom_range(0, 7)],
                    ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 12)));
          k++;
        end else if (r < 70) begin
          send_item(FUNC_ADD, 6'($urandom), 6'($urandom), 8'($urandom));
          k++;
        end else if (r < 90) begin
          send_item(FUNC_SOLVE, 6'($urandom), 6'($urandom), 8'($urandom));
        end else if (r < 95) begin
          send_item(FUNC_NOP, 6'($urandom), 6'($urandom), 8'($urandom));
        end else begin
          send_item(FUNC_CLEAR, 6'($urandom), 6'($urandom), 8'($urandom));
          k = 0;
        end
        if ($urandom_range(0, 15) == 0) burst_mode = !burst_mode;
      end
      send_item(FUNC_SOLVE, 6'($urandom), 6'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_NOP;
    in_src_vertex = '0;
    in_dst_vertex = '0;
    in_edge_capacity = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_SOURCE;
    cfg_wdata = '0;
    cycles = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    solves_sent = 0;
    errors_seen = 0;
    burst_mode = 0;
    pred_src = 6'd0;
    pred_sink = 6'd1;
    tbl_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_random_graphs();
    wait_idle();
    repeat (50) @(posedge clk);

    $display("Sent %0d items (%0d solves); checked %0d results, %0d full-table reports.",
             items_sent, solves_sent, results_seen, errors_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
